// ===== hw/rtl/lpc_pkg.sv =====
// Shared types and constants for the looping playhead counter.
// Holds field widths, operation and register codes, and the payload structs.
// No dependencies.
package lpc_pkg;

  localparam int POS_BITS = 48;
  localparam int BLK_BITS = 16;
  localparam int OP_BITS  = 3;
  localparam int IDX_BITS = 2;

  // Transport operations
  localparam logic [OP_BITS-1:0] OP_ADVANCE      = 3'd0;
  localparam logic [OP_BITS-1:0] OP_PLAY         = 3'd1;
  localparam logic [OP_BITS-1:0] OP_STOP         = 3'd2;
  localparam logic [OP_BITS-1:0] OP_TOGGLE       = 3'd3;
  localparam logic [OP_BITS-1:0] OP_RETURN       = 3'd4;
  localparam logic [OP_BITS-1:0] OP_SET_RECORD   = 3'd5;
  localparam logic [OP_BITS-1:0] OP_SET_POSITION = 3'd6;

  // Configuration register indexes
  localparam logic [IDX_BITS-1:0] REG_LOOP_ENABLE = 2'd0;
  localparam logic [IDX_BITS-1:0] REG_LOOP_START  = 2'd1;
  localparam logic [IDX_BITS-1:0] REG_LOOP_END    = 2'd2;

  typedef struct packed {
    logic [OP_BITS-1:0]         operation;
    logic [BLK_BITS-1:0]        sample_count;
    logic                       record_flag;
    logic signed [POS_BITS-1:0] new_position;
  } event_t;

  typedef struct packed {
    logic [POS_BITS-1:0] block_start;
    logic                is_playing;
    logic                is_recording;
  } status_t;

endpackage

// ===== hw/rtl/lpc_rem_unit.sv =====
// Bit-serial restoring remainder unit: one dividend bit per cycle.
// Computes dividend mod divisor for a WIDTH+1 bit dividend and WIDTH bit divisor.
// Depends on lpc_pkg for the default width.
module lpc_rem_unit #(
  parameter int WIDTH = lpc_pkg::POS_BITS
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [WIDTH:0]   dividend,
  input  logic [WIDTH-1:0] divisor,
  output logic             done,
  output logic [WIDTH-1:0] remainder
);

  localparam int STEPS    = WIDTH + 1;
  localparam int CNT_BITS = $clog2(STEPS + 1);

  logic [WIDTH:0]      shift_in;
  logic [WIDTH-1:0]    dvsr;
  logic [CNT_BITS-1:0] cnt;
  logic                busy;
  logic [WIDTH:0]      trial;
  logic                fits;

  // One shared compare-and-subtract per cycle
  assign trial = {remainder, shift_in[WIDTH]};
  assign fits  = trial >= {1'b0, dvsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      if (start) begin
        busy      <= 1'b1;
        done      <= 1'b0;
        cnt       <= CNT_BITS'(STEPS);
        shift_in  <= dividend;
        dvsr      <= divisor;
        remainder <= '0;
      end else if (busy) begin
        remainder <= fits ? WIDTH'(trial - {1'b0, dvsr}) : trial[WIDTH-1:0];
        shift_in  <= {shift_in[WIDTH-1:0], 1'b0};
        cnt       <= cnt - CNT_BITS'(1);
        busy      <= (cnt != CNT_BITS'(1));
        done      <= (cnt == CNT_BITS'(1));
      end else begin
        done <= 1'b0;
      end
    end
  end

endmodule

// ===== hw/rtl/looping_playhead_counter.sv =====
// Top level of the looping playhead counter: transport state, sequencer, config.
// Depends on lpc_pkg and lpc_rem_unit.
//
// Usage:
//   Configuration: write loop_enable (index 0), loop_start (1) and loop_end (2)
//   through cfg_valid/cfg_ready/cfg_index/cfg_data while no event is in flight.
//   cfg_ready is always high; an unused index is dropped.
//   Events: one transaction on in_valid/in_ready carries an event_t. Each event
//   yields exactly one status_t transaction on out_valid/out_ready holding the
//   position before the event and both flags after it.
//   Sequence: an accepted event passes through an execute step and then a done
//   step, which moves its result into the output register. An advance that wraps
//   in an active loop runs the remainder unit between those steps (one dividend
//   bit a cycle). One event is in flight at a time. A new event is taken as soon
//   as the previous one has moved its result into the output register, even if
//   the receiver has not taken it yet.
//   Stall: while out_valid waits for out_ready the result holds, and a finished
//   event waits in its last step until the output register frees.
//   Reset: position 0, stopped, not recording, loop disabled with both loop
//   points at 0; no result is pending.
module looping_playhead_counter (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  lpc_pkg::event_t                       in_item,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output lpc_pkg::status_t                      out_item,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [lpc_pkg::IDX_BITS-1:0]          cfg_index,
  input  logic [lpc_pkg::POS_BITS-1:0]          cfg_data
);

  localparam int P = lpc_pkg::POS_BITS;
  localparam int B = lpc_pkg::BLK_BITS;

  typedef enum logic [1:0] {S_IDLE, S_EXEC, S_DIV, S_DONE} state_t;

  state_t          state;
  lpc_pkg::event_t item;
  logic [P:0]      sum;
  logic [P-1:0]    pos_new;
  logic [P-1:0]    position;
  logic            playing_flag;
  logic            recording_flag;
  logic            loop_enable;
  logic [P-1:0]    loop_start;
  logic [P-1:0]    loop_end;

  logic            div_start;
  logic            div_done;
  logic [P-1:0]    div_rem;
  logic            loop_active;
  logic            advancing;
  logic            wrap;
  logic            play_next;
  logic            rec_next;
  logic            out_free;

  assign in_ready  = (state == S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid || out_ready;

  // Wrap decision: only an advance that moves, inside an active loop, to or past its end
  assign loop_active = loop_enable && (loop_end > loop_start);
  assign advancing   = (item.operation == lpc_pkg::OP_ADVANCE) && playing_flag &&
                       (item.sample_count != '0);
  assign wrap        = advancing && loop_active && (sum >= {1'b0, loop_end});
  assign div_start   = (state == S_EXEC) && wrap;

  lpc_rem_unit #(.WIDTH(P)) u_rem (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (sum - {1'b0, loop_end}),
    .divisor   (loop_end - loop_start),
    .done      (div_done),
    .remainder (div_rem)
  );

  // Flags after the event
  always_comb begin
    play_next = playing_flag;
    rec_next  = recording_flag;
    case (item.operation)
      lpc_pkg::OP_PLAY: play_next = 1'b1;
      lpc_pkg::OP_STOP: begin
        play_next = 1'b0;
        rec_next  = 1'b0;
      end
      lpc_pkg::OP_TOGGLE: begin
        play_next = !playing_flag;
        if (playing_flag) rec_next = 1'b0;
      end
      lpc_pkg::OP_SET_RECORD: rec_next = item.record_flag;
      default: ;
    endcase
  end

  // Configuration writes; an unused index is dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      loop_enable <= 1'b0;
      loop_start  <= '0;
      loop_end    <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        lpc_pkg::REG_LOOP_ENABLE: loop_enable <= cfg_data[0];
        lpc_pkg::REG_LOOP_START:  loop_start  <= cfg_data;
        lpc_pkg::REG_LOOP_END:    loop_end    <= cfg_data;
        default: ;
      endcase
    end
  end

  // Sequencer, transport state and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      out_valid      <= 1'b0;
      position       <= '0;
      playing_flag   <= 1'b0;
      recording_flag <= 1'b0;
    end else begin
      // Drop a taken result unless a new one replaces it this cycle
      if (out_valid && out_ready && state != S_DONE) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            item  <= in_item;
            // Full sum, one bit wider so overshoot past the top is kept
            sum   <= {1'b0, position} + (P+1)'(in_item.sample_count);
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          if (wrap) begin
            state <= S_DIV;
          end else begin
            if (advancing) begin
              // Saturate at the top of the position range
              pos_new <= sum[P] ? {P{1'b1}} : sum[P-1:0];
            end else if (item.operation == lpc_pkg::OP_RETURN) begin
              pos_new <= '0;
            end else if (item.operation == lpc_pkg::OP_SET_POSITION) begin
              // Clamp a negative request to zero
              pos_new <= item.new_position[P-1] ? '0 : P'(item.new_position);
            end else begin
              pos_new <= position;
            end
            state <= S_DONE;
          end
        end
        S_DIV: begin
          if (div_done) begin
            pos_new <= loop_start + div_rem;
            state   <= S_DONE;
          end
        end
        S_DONE: begin
          // Hold until the output register frees, then commit and report
          if (out_free) begin
            out_item.block_start  <= position;
            out_item.is_playing   <= play_next;
            out_item.is_recording <= rec_next;
            out_valid             <= 1'b1;
            position              <= pos_new;
            playing_flag          <= play_next;
            recording_flag        <= rec_next;
            state                 <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== hw/rtl/lpc_checker.sv =====
// Port-level checker for the looping playhead counter, bound to the top level.
// Depends on lpc_pkg for the payload types.
module lpc_checker (
  input logic              clk,
  input logic              rst,
  input logic              in_valid,
  input logic              in_ready,
  input lpc_pkg::event_t   in_item,
  input logic              out_valid,
  input logic              out_ready,
  input lpc_pkg::status_t  out_item
);

  // Come out of reset idle with nothing pending
  a_reset_idle: assert property (@(posedge clk) $past(rst) |-> (!out_valid && in_ready))
    else $error("not idle after reset");

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_item)))
    else $error("stalled result changed");

  // One event at a time: busy right after an accepted transaction
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("accepted a second event while busy");

  // A result never appears in the cycle right after an accepted event
  a_no_early_result: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !$rose(out_valid))
    else $error("result appeared too early");

endmodule

bind looping_playhead_counter lpc_checker u_lpc_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_item   (in_item),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_item  (out_item)
);

// ===== tb/sv/lpc_transport_checker.sv =====
// Checker for the looping playhead counter: watches all three channels.
// Keeps its own copy of the transport state and compares every status transaction.
// Depends on lpc_pkg.
module lpc_transport_checker (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  input  logic                          in_ready,
  input  lpc_pkg::event_t               in_item,
  input  logic                          out_valid,
  input  logic                          out_ready,
  input  lpc_pkg::status_t              out_item,
  input  logic                          cfg_valid,
  input  logic                          cfg_ready,
  input  logic [lpc_pkg::IDX_BITS-1:0]  cfg_index,
  input  logic [lpc_pkg::POS_BITS-1:0]  cfg_data,
  output int                            outstanding,
  output int                            mismatches
);
  timeunit 1ns;
  timeprecision 1ps;

  import lpc_pkg::*;

  localparam logic [POS_BITS-1:0] POS_MAX = '1;
  localparam int PRINT_CAP = 40;

  logic [POS_BITS-1:0] playhead;
  logic                playing;
  logic                recording;
  logic                loop_on;
  logic [POS_BITS-1:0] loop_lo;
  logic [POS_BITS-1:0] loop_hi;

  status_t expected_status[$];

  task automatic report_mismatch(input string what, input logic [63:0] want,
                                 input logic [63:0] got);
    if (mismatches < PRINT_CAP)
      $display("[%0t] mismatch on %s: expected %0h, got %0h", $realtime, what, want, got);
    mismatches++;
  endtask

  // Apply one transport event to the tracked state; return the status it yields.
  function automatic status_t apply_transport_event(input event_t ev);
    status_t     res;
    logic [63:0] sum;
    logic [63:0] lo64;
    logic [63:0] hi64;
    res.block_start = playhead;
    lo64 = {16'b0, loop_lo};
    hi64 = {16'b0, loop_hi};
    case (ev.operation)
      OP_ADVANCE: begin
        if (playing && ev.sample_count != '0) begin
          sum = {16'b0, playhead} + {48'b0, ev.sample_count};
          // wrap on the unsaturated sum
          if (loop_on && hi64 > lo64 && sum >= hi64) begin
            sum = lo64 + (sum - hi64) % (hi64 - lo64);
            playhead = sum[POS_BITS-1:0];
          end else if (sum > {16'b0, POS_MAX}) begin
            playhead = POS_MAX;
          end else begin
            playhead = sum[POS_BITS-1:0];
          end
        end
      end
      OP_PLAY:     playing = 1'b1;
      OP_STOP: begin
        playing   = 1'b0;
        recording = 1'b0;
      end
      OP_TOGGLE: begin
        if (playing) begin
          playing   = 1'b0;
          recording = 1'b0;
        end else begin
          playing = 1'b1;
        end
      end
      OP_RETURN:       playhead = '0;
      OP_SET_RECORD:   recording = ev.record_flag;
      OP_SET_POSITION: playhead = ev.new_position[POS_BITS-1] ? '0 : ev.new_position;
      default: ;
    endcase
    res.is_playing   = playing;
    res.is_recording = recording;
    return res;
  endfunction

  initial begin
    mismatches  = 0;
    outstanding = 0;
  end

  always @(posedge clk) begin
    status_t want;
    if (rst) begin
      playhead  = '0;
      playing   = 1'b0;
      recording = 1'b0;
      loop_on   = 1'b0;
      loop_lo   = '0;
      loop_hi   = '0;
      expected_status.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_LOOP_ENABLE: loop_on = cfg_data[0];
          REG_LOOP_START:  loop_lo = cfg_data;
          REG_LOOP_END:    loop_hi = cfg_data;
          default: ;
        endcase
      end
      // pop before push: a result leaving now belongs to an older event
      if (out_valid && out_ready) begin
        if (expected_status.size() == 0) begin
          report_mismatch("status with no event pending", '0, {16'b0, out_item.block_start});
        end else begin
          want = expected_status.pop_front();
          if (out_item.block_start !== want.block_start)
            report_mismatch("block_start", {16'b0, want.block_start},
                            {16'b0, out_item.block_start});
          if (out_item.is_playing !== want.is_playing)
            report_mismatch("is_playing", {63'b0, want.is_playing},
                            {63'b0, out_item.is_playing});
          if (out_item.is_recording !== want.is_recording)
            report_mismatch("is_recording", {63'b0, want.is_recording},
                            {63'b0, out_item.is_recording});
        end
      end
      if (in_valid && in_ready)
        expected_status.push_back(apply_transport_event(in_item));
    end
    outstanding <= expected_status.size();
  end

endmodule

// ===== tb/sv/looping_playhead_counter_tb.sv =====
// Testbench top for the looping playhead counter: clock, reset, stimulus and verdict.
// Depends on lpc_pkg, looping_playhead_counter and lpc_transport_checker.
module looping_playhead_counter_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import lpc_pkg::*;

  localparam logic [OP_BITS-1:0]  OP_UNDEFINED = 3'd7;
  localparam logic [IDX_BITS-1:0] REG_UNUSED   = 2'd3;
  localparam logic [POS_BITS-1:0] POS_MAX      = '1;
  localparam int ITEMS_PER_PHASE = 104;
  localparam int PHASES          = 8;
  localparam int LONG_STALL      = 300;
  localparam int CYCLE_LIMIT     = 1000000;

  logic                clk;
  logic                rst;
  logic                in_valid;
  logic                in_ready;
  event_t              in_item;
  logic                out_valid;
  logic                out_ready;
  status_t             out_item;
  logic                cfg_valid;
  logic                cfg_ready;
  logic [IDX_BITS-1:0] cfg_index;
  logic [POS_BITS-1:0] cfg_data;

  int outstanding;
  int mismatches;
  int send_idle_pct;
  int recv_idle_pct;
  int stall_requests;
  int cycle_count;

  looping_playhead_counter u_top (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  lpc_transport_checker u_checker (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_item     (in_item),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_item    (out_item),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .outstanding (outstanding),
    .mismatches  (mismatches)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Watchdog: end the run if the block hangs or crawls.
  initial begin : watchdog
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("looping_playhead_counter regression: fail");
    $finish;
  end

  // Status receiver. Drop ready at random per the current idle rate, and
  // hold it low for a long stretch whenever the stimulus asks for one, so the
  // block fills up and has to stall its event input.
  initial begin : status_receiver
    int stalls_served;
    stalls_served = 0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (stall_requests != stalls_served) begin
        stalls_served++;
        out_ready <= 1'b0;
        repeat (LONG_STALL - 1) @(posedge clk);
      end else begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  function automatic logic [POS_BITS-1:0] rand48();
    return POS_BITS'({$urandom, $urandom});
  endfunction

  // Offer one event. Valid stays high from one accepted transaction to the
  // next unless the sender decides to idle first.
  task automatic send_event(input logic [OP_BITS-1:0] op, input logic [BLK_BITS-1:0] count,
                            input logic rec, input logic [POS_BITS-1:0] req_pos);
    event_t ev;
    ev.operation    = op;
    ev.sample_count = count;
    ev.record_flag  = rec;
    ev.new_position = req_pos;
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid <= 1'b1;
    in_item  <= ev;
    do @(posedge clk); while (!in_ready);
  endtask

  // Stop offering events and hold until every predicted status has arrived.
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  task automatic write_reg(input logic [IDX_BITS-1:0] idx, input logic [POS_BITS-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // Program all three loop registers back to back; optionally poke the
  // unused index first, which the block must drop.
  task automatic program_loop(input logic enable, input logic [POS_BITS-1:0] lo,
                              input logic [POS_BITS-1:0] hi, input bit poke_unused);
    if (poke_unused)
      write_reg(REG_UNUSED, rand48());
    write_reg(REG_LOOP_START, lo);
    write_reg(REG_LOOP_END, hi);
    write_reg(REG_LOOP_ENABLE, {{(POS_BITS-1){1'b0}}, enable});
    cfg_valid <= 1'b0;
  endtask

  // Random event aimed at the loop window [lo, hi): mostly advances and
  // position jumps around the window, with the rest of the transport mixed in.
  task automatic send_random_event(input logic [POS_BITS-1:0] lo, input logic [POS_BITS-1:0] hi);
    int                  pick;
    logic [OP_BITS-1:0]  op;
    logic [BLK_BITS-1:0] count;
    logic [POS_BITS-1:0] span;
    logic [POS_BITS-1:0] req_pos;
    pick = $urandom_range(99);
    if      (pick < 45) op = OP_ADVANCE;
    else if (pick < 55) op = OP_PLAY;
    else if (pick < 60) op = OP_STOP;
    else if (pick < 68) op = OP_TOGGLE;
    else if (pick < 73) op = OP_RETURN;
    else if (pick < 81) op = OP_SET_RECORD;
    else if (pick < 96) op = OP_SET_POSITION;
    else                op = OP_UNDEFINED;
    case ($urandom_range(9))
      0:       count = '0;
      1, 2, 3: count = BLK_BITS'($urandom_range(255));
      default: count = BLK_BITS'($urandom_range(16'hFFFF));
    endcase
    span = (hi > lo && hi - lo < 48'h10_0000) ? hi - lo : 48'h1000;
    // full-range requests hit the negative clamp about half the time
    if ($urandom_range(3) == 0)
      req_pos = rand48();
    else
      req_pos = lo - POS_BITS'(64) + POS_BITS'($urandom_range(int'(span) + 128));
    send_event(op, count, 1'($urandom_range(1)), req_pos);
  endtask

  initial begin : stimulus
    logic                loop_en;
    logic [POS_BITS-1:0] loop_lo;
    logic [POS_BITS-1:0] loop_hi;
    rst            <= 1'b1;
    in_valid       <= 1'b0;
    in_item        <= '0;
    cfg_valid      <= 1'b0;
    cfg_index      <= '0;
    cfg_data       <= '0;
    send_idle_pct  = 31;
    recv_idle_pct  = 51;
    stall_requests = 0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part, loop disabled from reset.
    send_event(OP_ADVANCE, 16'd100, 1'b0, '0);          // advance while stopped
    send_event(OP_SET_RECORD, '0, 1'b1, '0);            // arm recording while stopped
    send_event(OP_PLAY, '0, 1'b0, '0);
    send_event(OP_ADVANCE, '0, 1'b0, '0);               // zero-length block
    send_event(OP_ADVANCE, 16'hFFFF, 1'b0, '0);
    send_event(OP_ADVANCE, 16'd1, 1'b0, '0);
    send_event(OP_STOP, '0, 1'b0, '0);                  // stop also clears recording
    send_event(OP_TOGGLE, '0, 1'b0, '0);                // toggle from stopped plays
    send_event(OP_SET_RECORD, '0, 1'b1, '0);
    send_event(OP_TOGGLE, '0, 1'b0, '0);                // toggle from playing stops
    send_event(OP_SET_POSITION, '0, 1'b0, 48'h8000_0000_0000); // most negative request
    send_event(OP_SET_POSITION, '0, 1'b0, POS_MAX);     // minus one clamps too
    send_event(OP_SET_POSITION, '0, 1'b0, 48'h7FFF_FFFF_FFFF);
    send_event(OP_PLAY, '0, 1'b0, '0);
    send_event(OP_ADVANCE, 16'hFFFF, 1'b0, '0);         // carry into the top position bit
    send_event(OP_UNDEFINED, 16'hFFFF, 1'b1, POS_MAX);  // undefined code leaves state alone
    send_event(OP_RETURN, '0, 1'b0, '0);
    send_event(OP_SET_RECORD, '0, 1'b0, '0);

    // Loop of length one: every wrap lands on the loop start.
    drain_results();
    program_loop(1'b1, 48'd1000, 48'd1001, 1'b1);
    send_event(OP_SET_POSITION, '0, 1'b0, 48'd500);
    send_event(OP_ADVANCE, 16'hFFFF, 1'b0, '0);
    send_event(OP_ADVANCE, 16'd3, 1'b0, '0);

    // Short loop entered from below, then a block much longer than the loop.
    drain_results();
    program_loop(1'b1, 48'd100, 48'd107, 1'b0);
    send_event(OP_SET_POSITION, '0, 1'b0, 48'd10);
    send_event(OP_ADVANCE, 16'd50, 1'b0, '0);
    send_event(OP_ADVANCE, 16'hFFFF, 1'b0, '0);
    send_event(OP_ADVANCE, 16'd47, 1'b0, '0);

    // Random part: one loop setting per phase, the extremes among them.
    for (int phase = 0; phase < PHASES; phase++) begin
      if (phase < 3) begin
        send_idle_pct = 31;
        recv_idle_pct = 51;
      end else if (phase < 6) begin
        send_idle_pct = 51;
        recv_idle_pct = 31;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      loop_en = 1'b1;
      case (phase)
        0: begin
          loop_lo = POS_BITS'($urandom_range(5000));
          loop_hi = loop_lo + POS_BITS'($urandom_range(200000, 1));
        end
        1: begin                                   // valid window, looping off
          loop_en = 1'b0;
          loop_lo = POS_BITS'($urandom_range(5000));
          loop_hi = loop_lo + POS_BITS'($urandom_range(100000, 1));
        end
        2: begin                                   // widest possible window
          loop_lo = '0;
          loop_hi = POS_MAX;
        end
        3: begin                                   // end equal to start: inactive
          loop_lo = POS_BITS'($urandom_range(100000));
          loop_hi = loop_lo;
        end
        4: begin                                   // end below start: inactive
          loop_hi = rand48();
          loop_lo = rand48();
          if (loop_hi == POS_MAX) loop_hi = loop_hi - 48'd1;
          if (loop_lo <= loop_hi)
            loop_lo = loop_hi + 48'd1 + (rand48() % (POS_MAX - loop_hi));
        end
        5: begin                                   // tiny loop far up the timeline
          loop_lo = rand48() >> 1;
          loop_hi = loop_lo + POS_BITS'($urandom_range(64, 1));
        end
        6: begin
          loop_lo = rand48() >> 2;
          loop_hi = loop_lo + POS_BITS'($urandom_range(262140, 1));
        end
        default: begin                             // loop right at zero
          loop_lo = '0;
          loop_hi = POS_BITS'($urandom_range(16, 1));
        end
      endcase
      drain_results();
      program_loop(loop_en, loop_lo, loop_hi, phase % 2 == 0);
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        // Hold the receiver off while the sender keeps pushing.
        if (phase == 1 && n == 10)
          stall_requests++;
        // Let the sender go quiet until everything in flight has come back.
        if (phase == 4 && n == ITEMS_PER_PHASE / 2)
          drain_results();
        send_random_event(loop_lo, loop_hi);
      end
    end

    // Let the last status transactions land, then allow a full wrap's worth
    // of cycles for anything stray.
    drain_results();
    repeat (POS_BITS + 16) @(posedge clk);
    if (mismatches == 0) begin
      $display("looping_playhead_counter regression: pass");
    end else begin
      $display("looping_playhead_counter regression: fail");
    end
    $finish;
  end

endmodule
